// ----- src/fem_pkg.sv -----
// ----------------------------------------------------------------------------
// fem_pkg
// Shared types and constants for the flash erase map tracker.
// ----------------------------------------------------------------------------
package fem_pkg;

    localparam int NUM_BLOCKS     = 16384;
    localparam int MAX_REQ_BLOCKS = 128;

    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int MAP_DEPTH = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int BLK_W     = $clog2(NUM_BLOCKS);
    localparam int RUN_W     = $clog2(MAX_REQ_BLOCKS + 1);

    localparam int OFF_W = 26;
    localparam int CNT_W = 27;
    localparam int LEN_W = 24;
    localparam int ST_W  = 2;
    localparam int SH_W  = 5;
    localparam int ESZ_W = 17;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam logic [SH_W-1:0]  SHIFT_LO  = 5'd12;
    localparam logic [SH_W-1:0]  SHIFT_HI  = 5'd16;
    localparam logic [CNT_W-1:0] FLASH_CAP = 27'd67108864;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD   = 2'd2;

    localparam logic ACT_ERASE = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic REG_SHIFT = 1'b0;
    localparam logic REG_FLASH = 1'b1;

    typedef struct packed {
        logic             action;
        logic [OFF_W-1:0] byte_offset;
        logic [CNT_W-1:0] byte_count;
    } req_t;

    typedef struct packed {
        logic             has_run;
        logic [OFF_W-1:0] run_start;
        logic [LEN_W-1:0] run_length;
        logic [ST_W-1:0]  status;
        logic             last;
    } res_t;

endpackage

// ----- src/fem_ram.sv -----
// ----------------------------------------------------------------------------
// fem_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fem_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/flash_erase_map_tracker.sv -----
// ----------------------------------------------------------------------------
// flash_erase_map_tracker
// Erased/dirty map of flash erase blocks; turns erase requests into runs.
// ----------------------------------------------------------------------------
// Range or alignment errors and zero-length writes: result set in the check state, no map access.
// Write: each map word (32 blocks) touched is read, cleared under a mask and written back.
// Erase: each map word is read, walked one block per cycle and written back,
//   through the single read/write port pair of the map RAM.
// One transaction in flight; results come one per cycle at most, never stalled.
// Reset: busy for a clearing pass over all 512 map words that marks every block dirty.
// ----------------------------------------------------------------------------
module flash_erase_map_tracker
    import fem_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  req_t              req,
    output logic              rsp_valid,
    output res_t              rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_LD   = 4'd4;
    localparam logic [3:0] S_BIT  = 4'd5;
    localparam logic [3:0] S_WB   = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_LAST = 4'd8;
    localparam logic [3:0] S_MRD  = 4'd9;
    localparam logic [3:0] S_MLD  = 4'd10;
    localparam logic [3:0] S_MWB  = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [SH_W-1:0]   shift_reg, shift_next;
    logic [CNT_W-1:0]  flash_reg, flash_next;
    req_t              req_reg, req_next;
    logic [BLK_W-1:0]  cur_blk_reg, cur_blk_next;
    logic [BLK_W-1:0]  end_blk_reg, end_blk_next;
    logic [MAP_AW-1:0] widx_reg, widx_next;
    logic [RUN_W-1:0]  left_reg, left_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [BLK_W-1:0]  open_start_reg, open_start_next;
    logic [RUN_W-1:0]  open_blocks_reg, open_blocks_next;
    logic [BLK_W-1:0]  pend_start_reg, pend_start_next;
    logic [RUN_W-1:0]  pend_blocks_reg, pend_blocks_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              rsp_valid_reg, rsp_valid_next;
    res_t              rsp_reg, rsp_next;

    logic [SH_W-1:0]   sh;
    logic [CNT_W-1:0]  flash_eff;
    logic [ESZ_W-1:0]  esz_m1;
    logic [CNT_W:0]    end_sum;
    logic [CNT_W+1:0]  blk_end;
    logic [CNT_W:0]    nb;
    logic [OFF_W-1:0]  first_full;
    logic [BLK_W-1:0]  first_blk;
    logic              beyond;
    logic              bad;
    logic [CNT_W-1:0]  cnt_blocks;
    logic [BIT_W-1:0]  bit_idx;
    logic [BIT_W-1:0]  lo_bit;
    logic [BIT_W-1:0]  hi_bit;
    logic [WORD_W-1:0] mask;
    logic              cfg_wr;
    logic              ram_we;
    logic [MAP_AW-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    res_t              pend_run;

    fem_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (widx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pready    = 1'b1;
    assign busy      = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_wr    = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_SHIFT: prdata = {{(CFG_DW-SH_W){1'b0}}, shift_reg};
            REG_FLASH: prdata = {{(CFG_DW-CNT_W){1'b0}}, flash_reg};
            default:   prdata = '0;
        endcase
    end

    always_comb
    begin
        if (shift_reg < SHIFT_LO)
        begin
            sh = SHIFT_LO;
        end
        else if (shift_reg > SHIFT_HI)
        begin
            sh = SHIFT_HI;
        end
        else
        begin
            sh = shift_reg;
        end
        flash_eff  = (flash_reg > FLASH_CAP) ? FLASH_CAP : flash_reg;
        esz_m1     = ESZ_W'((18'd1 << sh) - 18'd1);
        end_sum    = {2'b00, req_reg.byte_offset} + {1'b0, req_reg.byte_count};
        blk_end    = ({1'b0, end_sum} + {(CNT_W+2-ESZ_W)'(0), esz_m1}) >> sh;
        nb         = ({1'b0, req_reg.byte_count} + {(CNT_W+1-ESZ_W)'(0), esz_m1}) >> sh;
        first_full = req_reg.byte_offset >> sh;
        first_blk  = first_full[BLK_W-1:0];
        cnt_blocks = req_reg.byte_count >> sh;
        beyond     = (end_sum > {1'b0, flash_eff})
                     || ((req_reg.byte_count != '0)
                         && (blk_end > (CNT_W+2)'(NUM_BLOCKS)));
        bad        = ((req_reg.byte_offset & {(OFF_W-ESZ_W)'(0), esz_m1}) != '0)
                     || ((req_reg.byte_count & {(CNT_W-ESZ_W)'(0), esz_m1}) != '0)
                     || (cnt_blocks > CNT_W'(MAX_REQ_BLOCKS));
        bit_idx    = cur_blk_reg[BIT_W-1:0];
        lo_bit     = (widx_reg == cur_blk_reg[BLK_W-1:BIT_W]) ? cur_blk_reg[BIT_W-1:0] : '0;
        hi_bit     = (widx_reg == end_blk_reg[BLK_W-1:BIT_W]) ? end_blk_reg[BIT_W-1:0]
                                                              : BIT_W'(WORD_W - 1);
        mask       = ({WORD_W{1'b1}} << lo_bit)
                     & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_bit));
        ram_we     = (state_reg == S_CLR) || (state_reg == S_WB) || (state_reg == S_MWB);
        ram_wdata  = (state_reg == S_CLR) ? '0 : word_reg;
        ram_raddr  = (state_reg == S_MRD) ? widx_reg : cur_blk_reg[BLK_W-1:BIT_W];

        pend_run.has_run    = 1'b1;
        pend_run.run_start  = OFF_W'({{(OFF_W-BLK_W){1'b0}}, pend_start_reg} << sh);
        pend_run.run_length = LEN_W'({{(LEN_W-RUN_W){1'b0}}, pend_blocks_reg} << sh);
        pend_run.status     = ST_OK;
        pend_run.last       = 1'b0;
    end

    always_comb
    begin
        state_next       = state_reg;
        shift_next       = shift_reg;
        flash_next       = flash_reg;
        req_next         = req_reg;
        cur_blk_next     = cur_blk_reg;
        end_blk_next     = end_blk_reg;
        widx_next        = widx_reg;
        left_next        = left_reg;
        word_next        = word_reg;
        open_start_next  = open_start_reg;
        open_blocks_next = open_blocks_reg;
        pend_start_next  = pend_start_reg;
        pend_blocks_next = pend_blocks_reg;
        pend_valid_next  = pend_valid_reg;
        rsp_valid_next   = 1'b0;
        rsp_next         = rsp_reg;

        if (cfg_wr)
        begin
            case (paddr[2])
                REG_SHIFT: shift_next = pwdata[SH_W-1:0];
                REG_FLASH: flash_next = pwdata[CNT_W-1:0];
                default:   shift_next = shift_reg;
            endcase
        end

        case (state_reg)
            S_CLR:
            begin
                widx_next = widx_reg + 1'b1;
                if (widx_reg == MAP_AW'(MAP_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                rsp_next         = '0;
                rsp_next.last    = 1'b1;
                cur_blk_next     = first_blk;
                end_blk_next     = first_blk + BLK_W'(nb) - 1'b1;
                widx_next        = first_blk[BLK_W-1:BIT_W];
                left_next        = cnt_blocks[RUN_W-1:0];
                open_blocks_next = '0;
                pend_valid_next  = 1'b0;
                if (beyond)
                begin
                    rsp_next.status = ST_RANGE;
                    rsp_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (req_reg.action == ACT_WRITE)
                begin
                    if (nb == '0)
                    begin
                        rsp_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_MRD;
                    end
                end
                else if (bad)
                begin
                    rsp_next.status = ST_BAD;
                    rsp_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (cnt_blocks == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                widx_next  = cur_blk_reg[BLK_W-1:BIT_W];
                state_next = S_LD;
            end
            S_LD:
            begin
                word_next  = ram_rdata;
                state_next = S_BIT;
            end
            S_BIT:
            begin
                word_next[bit_idx] = 1'b1;
                if (!word_reg[bit_idx])
                begin
                    if (open_blocks_reg == '0)
                    begin
                        open_start_next = cur_blk_reg;
                    end
                    open_blocks_next = open_blocks_reg + 1'b1;
                end
                else if (open_blocks_reg != '0)
                begin
                    if (pend_valid_reg)
                    begin
                        rsp_next       = pend_run;
                        rsp_valid_next = 1'b1;
                    end
                    pend_start_next  = open_start_reg;
                    pend_blocks_next = open_blocks_reg;
                    pend_valid_next  = 1'b1;
                    open_blocks_next = '0;
                end
                cur_blk_next = cur_blk_reg + 1'b1;
                left_next    = left_reg - 1'b1;
                if ((left_reg == RUN_W'(1)) || (bit_idx == BIT_W'(WORD_W - 1)))
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                state_next = (left_reg == '0) ? S_FIN : S_RD;
            end
            S_FIN:
            begin
                if (open_blocks_reg != '0)
                begin
                    if (pend_valid_reg)
                    begin
                        rsp_next       = pend_run;
                        rsp_valid_next = 1'b1;
                    end
                    pend_start_next  = open_start_reg;
                    pend_blocks_next = open_blocks_reg;
                    pend_valid_next  = 1'b1;
                    open_blocks_next = '0;
                end
                state_next = S_LAST;
            end
            S_LAST:
            begin
                if (pend_valid_reg)
                begin
                    rsp_next = pend_run;
                end
                else
                begin
                    rsp_next = '0;
                end
                rsp_next.last   = 1'b1;
                rsp_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
                state_next      = S_IDLE;
            end
            S_MRD:
            begin
                state_next = S_MLD;
            end
            S_MLD:
            begin
                word_next  = ram_rdata & ~mask;
                state_next = S_MWB;
            end
            S_MWB:
            begin
                if (widx_reg == end_blk_reg[BLK_W-1:BIT_W])
                begin
                    rsp_next       = '0;
                    rsp_next.last  = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    widx_next  = widx_reg + 1'b1;
                    state_next = S_MRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLR;
            shift_reg       <= SHIFT_LO;
            flash_reg       <= FLASH_CAP;
            widx_reg        <= '0;
            left_reg        <= '0;
            open_blocks_reg <= '0;
            pend_valid_reg  <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            shift_reg       <= shift_next;
            flash_reg       <= flash_next;
            widx_reg        <= widx_next;
            left_reg        <= left_next;
            open_blocks_reg <= open_blocks_next;
            pend_valid_reg  <= pend_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        cur_blk_reg     <= cur_blk_next;
        end_blk_reg     <= end_blk_next;
        word_reg        <= word_next;
        open_start_reg  <= open_start_next;
        pend_start_reg  <= pend_start_next;
        pend_blocks_reg <= pend_blocks_next;
        rsp_reg         <= rsp_next;
    end

endmodule

// ----- src/fem_checker.sv -----
// ----------------------------------------------------------------------------
// fem_checker
// Port-level checks for the flash erase map tracker.
// ----------------------------------------------------------------------------
module fem_checker
    import fem_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic rsp_valid,
    input res_t rsp
);

    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.has_run |-> rsp.last)
    else $error("status result not marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> !rsp.has_run)
    else $error("error status on a run command");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.has_run |-> (rsp.run_length != '0))
    else $error("run command with zero length");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> busy)
    else $error("transaction ended without a last result");

endmodule

bind flash_erase_map_tracker fem_checker u_fem_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
);
